### rtl/cfp_pkg.sv
`default_nettype none
package cfp_pkg;

    localparam int AGENDA_MAX = 8;
    localparam logic [9:0] POS_LIMIT = 10'd1023;
    localparam logic [31:0] EPOCH_FLOOR = 32'd1577836800;
    localparam logic [31:0] PROGRESS_MAX = 32'd604800000;

    // message kinds
    localparam logic [3:0] K_UPSERT = 4'd0;
    localparam logic [3:0] K_REMOVE = 4'd1;
    localparam logic [3:0] K_CLEAR = 4'd2;
    localparam logic [3:0] K_MEDIA = 4'd3;
    localparam logic [3:0] K_PROGRESS = 4'd4;
    localparam logic [3:0] K_AGENDA = 4'd5;
    localparam logic [3:0] K_BATTERY = 4'd6;
    localparam logic [3:0] K_CALL = 4'd7;
    localparam logic [3:0] K_REPLY = 4'd8;
    localparam logic [3:0] K_WIFI_CLEAR = 4'd9;
    localparam logic [3:0] K_PEER_FORGET = 4'd10;
    localparam logic [3:0] K_WIFI_PROV = 4'd11;
    localparam logic [3:0] K_WX_SET = 4'd12;
    localparam logic [3:0] K_WX_SNAP = 4'd13;
    localparam logic [3:0] K_UNKNOWN = 4'd14;

    // field identifiers
    localparam logic [5:0] F_REMOVE_ID = 6'd0;
    localparam logic [5:0] F_MEDIA_FLAGS = 6'd1;
    localparam logic [5:0] F_MEDIA_TITLE = 6'd2;
    localparam logic [5:0] F_MEDIA_ARTIST = 6'd3;
    localparam logic [5:0] F_PROG_FLAGS = 6'd4;
    localparam logic [5:0] F_PROG_POS = 6'd5;
    localparam logic [5:0] F_PROG_DUR = 6'd6;
    localparam logic [5:0] F_PROG_TITLE = 6'd7;
    localparam logic [5:0] F_PROG_ARTIST = 6'd8;
    localparam logic [5:0] F_AG_COUNT = 6'd9;
    localparam logic [5:0] F_AG_START = 6'd10;
    localparam logic [5:0] F_AG_END = 6'd11;
    localparam logic [5:0] F_AG_FLAGS = 6'd12;
    localparam logic [5:0] F_AG_TITLE = 6'd13;
    localparam logic [5:0] F_AG_LOC = 6'd14;
    localparam logic [5:0] F_BAT_PCT = 6'd15;
    localparam logic [5:0] F_BAT_FLAGS = 6'd16;
    localparam logic [5:0] F_CALL_FLAGS = 6'd17;
    localparam logic [5:0] F_CALL_SESSION = 6'd18;
    localparam logic [5:0] F_CALL_GEN = 6'd19;
    localparam logic [5:0] F_CALL_LABEL = 6'd20;
    localparam logic [5:0] F_RPL_STATUS = 6'd21;
    localparam logic [5:0] F_RPL_NOTIF = 6'd22;
    localparam logic [5:0] F_RPL_NONCE = 6'd23;
    localparam logic [5:0] F_WP_SSID_LEN = 6'd24;
    localparam logic [5:0] F_WP_PASS_LEN = 6'd25;
    localparam logic [5:0] F_WP_SSID = 6'd26;
    localparam logic [5:0] F_WP_PASS = 6'd27;
    localparam logic [5:0] F_WS_FLAGS = 6'd28;
    localparam logic [5:0] F_WS_METRIC = 6'd29;
    localparam logic [5:0] F_WS_REFRESH = 6'd30;
    localparam logic [5:0] F_WS_LAT = 6'd31;
    localparam logic [5:0] F_WS_LON = 6'd32;
    localparam logic [5:0] F_SN_FLAGS = 6'd33;
    localparam logic [5:0] F_SN_OBSERVED = 6'd34;
    localparam logic [5:0] F_SN_AGE = 6'd35;
    localparam logic [5:0] F_SN_TEMP = 6'd36;
    localparam logic [5:0] F_SN_APPARENT = 6'd37;
    localparam logic [5:0] F_SN_CODE = 6'd38;
    localparam logic [5:0] F_SN_WIND = 6'd39;
    localparam logic [5:0] F_UP_ID = 6'd40;
    localparam logic [5:0] F_UP_CATEGORY = 6'd41;
    localparam logic [5:0] F_UP_APP = 6'd42;
    localparam logic [5:0] F_UP_TITLE = 6'd43;
    localparam logic [5:0] F_UP_BODY = 6'd44;
    localparam logic [5:0] F_VERDICT = 6'd0;

    localparam logic CFG_VERSION = 1'b0;
    localparam logic CFG_MAX_CAT = 1'b1;

    typedef struct packed {
        logic [9:0]  pos;
        logic [7:0]  mtype;
        logic [7:0]  flags;
        logic [7:0]  l1;
        logic [7:0]  l2;
        logic [15:0] l3;
        logic [31:0] asmw;
        logic [31:0] hf;
        logic [31:0] hs;
        logic        rej;
        logic [3:0]  ecnt;
        logic [3:0]  eidx;
        logic [6:0]  eoff;
    } parse_st_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic [5:0]         field_id;
        logic [6:0]         item_index;
        logic signed [32:0] value;
        logic               is_verdict;
        logic               accepted;
        logic               last;
    } result_t;

    function automatic logic [3:0] kind_of(input logic [7:0] t);
        logic [3:0] k;
        unique case (t)
            8'h01: k = K_UPSERT;
            8'h02: k = K_REMOVE;
            8'h03: k = K_CLEAR;
            8'h04: k = K_MEDIA;
            8'h07: k = K_PROGRESS;
            8'h05: k = K_AGENDA;
            8'h06: k = K_BATTERY;
            8'h08: k = K_CALL;
            8'h24: k = K_REPLY;
            8'h22: k = K_WIFI_CLEAR;
            8'h25: k = K_PEER_FORGET;
            8'h20: k = K_WIFI_PROV;
            8'h21: k = K_WX_SET;
            8'h23: k = K_WX_SNAP;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

### rtl/cfp_frame_if.sv
`default_nettype none
interface cfp_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface
`default_nettype wire

### rtl/cfp_result_if.sv
`default_nettype none
interface cfp_result_if;
    logic               valid;
    logic               ready;
    logic [3:0]         kind;
    logic [5:0]         field_id;
    logic [6:0]         item_index;
    logic signed [32:0] value;
    logic               is_verdict;
    logic               accepted;
    logic               last;
    modport source (output valid, output kind, output field_id, output item_index,
                    output value, output is_verdict, output accepted, output last,
                    input ready);
    modport sink (input valid, input kind, input field_id, input item_index,
                  input value, input is_verdict, input accepted, input last,
                  output ready);
endinterface
`default_nettype wire

### rtl/companion_frame_parser_unit.sv
`default_nettype none
// Channel   | Dir | Payload                                          | Transfer when
// ----------+-----+--------------------------------------------------+--------------
// frame     | in  | frame_byte[7:0], frame_end                       | valid & ready
// result    | out | kind, field_id, item_index, value[32:0] signed,  | valid & ready
//           |     | is_verdict, accepted, last                       |
// cfg       | in  | cfg_we, cfg_index, cfg_data[7:0]                 | cfg_we
//
// One frame byte is taken per cycle while ready is high. Decode is combinational
// from the parse state registers; each byte yields up to two results (a field,
// then the verdict on frame_end), pushed into a four-entry result queue drained
// one per cycle unless result_ch stalls. Sustained rate: one byte per cycle, set by
// the queue drain; only the verdict byte adds a second result. ready drops while
// fewer than two queue slots are free. Reset (rst_n, async low) clears parse state,
// queue pointers and restores protocol_version 1 and max_category 5. A stalled
// result side backs up into the queue and then holds off frame transfers.
module companion_frame_parser_unit (
    input  logic                clk,
    input  logic                rst_n,
    cfp_frame_if.sink           frame_ch,
    cfp_result_if.source        result_ch,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data
);
    import cfp_pkg::*;

    parse_st_t  st_reg;
    parse_st_t  st_next;
    logic [7:0] version_reg;
    logic [5:0] max_cat_reg;
    logic       take;
    logic       fld_vld;
    logic       ver_vld;
    result_t    fld;
    result_t    ver;
    logic       room;
    logic       head_vld;
    result_t    head;

    // a byte transfer
    assign take           = frame_ch.valid && frame_ch.ready;
    assign frame_ch.ready = room;

    cfp_decode u_decode (
        .cur        (st_reg),
        .frame_byte (frame_ch.frame_byte),
        .frame_end  (frame_ch.frame_end),
        .version    (version_reg),
        .max_cat    (max_cat_reg),
        .nxt        (st_next),
        .fld_vld    (fld_vld),
        .fld        (fld),
        .ver_vld    (ver_vld),
        .ver        (ver)
    );

    cfp_result_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_a   (take && fld_vld),
        .data_a   (fld),
        .push_b   (take && ver_vld),
        .data_b   (ver),
        .room     (room),
        .head_vld (head_vld),
        .head     (head),
        .pop      (result_ch.valid && result_ch.ready)
    );

    assign result_ch.valid      = head_vld;
    assign result_ch.kind       = head.kind;
    assign result_ch.field_id   = head.field_id;
    assign result_ch.item_index = head.item_index;
    assign result_ch.value      = head.value;
    assign result_ch.is_verdict = head.is_verdict;
    assign result_ch.accepted   = head.accepted;
    assign result_ch.last       = head.last;

    // parse state advances only on a byte transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (take)
        begin
            st_reg <= st_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= 8'd1;
            max_cat_reg <= 6'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VERSION: version_reg <= cfg_data;
                CFG_MAX_CAT: max_cat_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && frame_ch.frame_end) |=> st_reg.pos == '0)
        else $error("parse state not cleared after frame end");
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !frame_ch.frame_end && st_reg.pos < POS_LIMIT)
        |=> st_reg.pos == $past(st_reg.pos) + 10'd1)
        else $error("byte position did not advance");
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> st_reg == $past(st_reg))
        else $error("parse state moved without a transfer");

endmodule
`default_nettype wire

### rtl/cfp_decode.sv
`default_nettype none
module cfp_decode (
    input  cfp_pkg::parse_st_t cur,
    input  logic [7:0]         frame_byte,
    input  logic               frame_end,
    input  logic [7:0]         version,
    input  logic [5:0]         max_cat,
    output cfp_pkg::parse_st_t nxt,
    output logic               fld_vld,
    output cfp_pkg::result_t   fld,
    output logic               ver_vld,
    output cfp_pkg::result_t   ver
);
    import cfp_pkg::*;

    typedef struct packed {
        logic       v;
        logic [5:0] fid;
        logic [6:0] idx;
    } txt_t;

    function automatic logic [31:0] gather(input logic [31:0] a, input logic [1:0] k,
                                           input logic [7:0] b);
        logic [31:0] r;
        if (k == 2'd0) r = {24'd0, b};
        else r = a | ({24'd0, b} << {k, 3'b000});
        return r;
    endfunction

    function automatic logic [1:0] lo2(input logic [9:0] x);
        return x[1:0];
    endfunction

    function automatic logic [7:0] clean(input logic [7:0] b);
        return (b >= 8'h20 && b <= 8'h7e) ? b : 8'h3f;
    endfunction

    function automatic txt_t text_run(input logic [9:0] off, input logic [15:0] a,
                                      input logic [15:0] c, input logic [15:0] d,
                                      input logic [5:0] fa, input logic [5:0] fb,
                                      input logic [5:0] fc);
        txt_t t;
        logic [16:0] o;
        t = '0;
        o = {7'd0, off};
        if (o < {1'b0, a}) begin
            t = '{v: 1'b1, fid: fa, idx: o[6:0]};
        end else begin
            o = o - {1'b0, a};
            if (o < {1'b0, c}) begin
                t = '{v: 1'b1, fid: fb, idx: o[6:0]};
            end else begin
                o = o - {1'b0, c};
                if (o < {1'b0, d}) t = '{v: 1'b1, fid: fc, idx: o[6:0]};
            end
        end
        return t;
    endfunction

    logic [9:0]         p;
    logic [7:0]         b;
    logic [3:0]         kd;
    parse_st_t          n;
    logic               fv;
    logic [5:0]         fid;
    logic [6:0]         fix;
    logic signed [32:0] fvl;
    logic [31:0]        w;
    logic signed [31:0] s32;
    logic signed [15:0] s16;
    txt_t               tx;
    logic [6:0]         o;
    logic [7:0]         al1;
    logic [7:0]         al2;
    logic               ok;
    logic               idle;
    logic [17:0]        nb;
    logic [3:0]         kv;

    always_comb
    begin
        n   = cur;
        p   = cur.pos;
        b   = frame_byte;
        kd  = kind_of(cur.mtype);
        fv  = 1'b0;
        fid = '0;
        fix = '0;
        fvl = '0;
        w   = '0;
        s32 = '0;
        s16 = '0;
        tx  = '0;
        o   = cur.eoff;
        al1 = cur.l1;
        al2 = cur.l2;
        if (p >= POS_LIMIT) begin
            n.rej = 1'b1;
        end else begin
            n.pos = p + 10'd1;
            if (p == 10'd0) begin
                if (b != version) n.rej = 1'b1;
            end else if (p == 10'd1) begin
                n.mtype = b;
                if (kind_of(b) == K_UNKNOWN) n.rej = 1'b1;
            end else begin
                case (kd)
                    K_UPSERT:
                    begin
                        if (p <= 10'd5) begin
                            w = gather(cur.asmw, lo2(p - 10'd2), b);
                            n.asmw = w;
                            if (p == 10'd5) begin
                                n.hf = w; fv = 1'b1; fid = F_UP_ID; fvl = {1'b0, w};
                                if (w == '0) n.rej = 1'b1;
                            end
                        end else if (p == 10'd6) begin
                            n.flags = b; fv = 1'b1; fid = F_UP_CATEGORY; fvl = {25'd0, b};
                            if (b[5:0] > max_cat) n.rej = 1'b1;
                        end else if (p == 10'd7) begin
                            n.l1 = b; if (b > 8'd24) n.rej = 1'b1;
                        end else if (p == 10'd8) begin
                            n.l2 = b; if (b > 8'd48) n.rej = 1'b1;
                        end else if (p == 10'd9) begin
                            n.l3 = {8'd0, b};
                        end else if (p == 10'd10) begin
                            n.l3 = cur.l3 | {b, 8'd0};
                            if (n.l3 > 16'd96) n.rej = 1'b1;
                        end else begin
                            tx = text_run(p - 10'd11, {8'd0, cur.l1}, {8'd0, cur.l2},
                                          cur.l3, F_UP_APP, F_UP_TITLE, F_UP_BODY);
                        end
                    end
                    K_REMOVE:
                    begin
                        if (p <= 10'd5) begin
                            w = gather(cur.asmw, lo2(p - 10'd2), b);
                            n.asmw = w;
                            if (p == 10'd5) begin
                                n.hf = w; fv = 1'b1; fid = F_REMOVE_ID; fvl = {1'b0, w};
                            end
                        end
                    end
                    K_MEDIA:
                    begin
                        if (p == 10'd2) begin
                            n.flags = b; fv = 1'b1; fid = F_MEDIA_FLAGS; fvl = {25'd0, b};
                            if (b[7:2] != '0) n.rej = 1'b1;
                        end else if (p == 10'd3) begin
                            n.l1 = b; if (b > 8'd48) n.rej = 1'b1;
                        end else if (p == 10'd4) begin
                            n.l2 = b; if (b > 8'd48) n.rej = 1'b1;
                        end else begin
                            tx = text_run(p - 10'd5, {8'd0, cur.l1}, {8'd0, cur.l2}, 16'd0,
                                          F_MEDIA_TITLE, F_MEDIA_ARTIST, F_MEDIA_ARTIST);
                        end
                    end
                    K_PROGRESS:
                    begin
                        if (p == 10'd2) begin
                            n.flags = b; fv = 1'b1; fid = F_PROG_FLAGS; fvl = {25'd0, b};
                            if (b[7:3] != '0) n.rej = 1'b1;
                        end else if (p == 10'd3) begin
                            n.l1 = b; if (b > 8'd48) n.rej = 1'b1;
                        end else if (p == 10'd4) begin
                            n.l2 = b; if (b > 8'd48) n.rej = 1'b1;
                        end else if (p <= 10'd8) begin
                            w = gather(cur.asmw, lo2(p - 10'd5), b);
                            n.asmw = w;
                            if (p == 10'd8) begin
                                n.hf = w; fv = 1'b1; fid = F_PROG_POS; fvl = {1'b0, w};
                            end
                        end else if (p <= 10'd12) begin
                            w = gather(cur.asmw, lo2(p - 10'd9), b);
                            n.asmw = w;
                            if (p == 10'd12) begin
                                n.hs = w; fv = 1'b1; fid = F_PROG_DUR; fvl = {1'b0, w};
                            end
                        end else begin
                            tx = text_run(p - 10'd13, {8'd0, cur.l1}, {8'd0, cur.l2}, 16'd0,
                                          F_PROG_TITLE, F_PROG_ARTIST, F_PROG_ARTIST);
                        end
                    end
                    K_AGENDA:
                    begin
                        if (p == 10'd2) begin
                            fv = 1'b1; fid = F_AG_COUNT; fvl = {25'd0, b};
                            if (b > 8'(AGENDA_MAX)) n.rej = 1'b1;
                            n.ecnt = (b > 8'd15) ? 4'd15 : b[3:0];
                        end else if (cur.eidx >= cur.ecnt) begin
                            n.rej = 1'b1;
                        end else begin
                            if (o < 7'd8) begin
                                w = gather(cur.asmw, o[1:0], b);
                                n.asmw = w;
                                if (o == 7'd3) begin
                                    n.hf = w; fv = 1'b1; fid = F_AG_START;
                                    fix = {3'd0, cur.eidx}; fvl = {1'b0, w};
                                end
                                if (o == 7'd7) begin
                                    n.hs = w; fv = 1'b1; fid = F_AG_END;
                                    fix = {3'd0, cur.eidx}; fvl = {1'b0, w};
                                end
                            end else if (o == 7'd8) begin
                                n.flags = b; fv = 1'b1; fid = F_AG_FLAGS;
                                fix = {3'd0, cur.eidx}; fvl = {25'd0, b};
                                if (b[7:1] != '0) n.rej = 1'b1;
                            end else if (o == 7'd9) begin
                                if (b > 8'd32) begin
                                    n.rej = 1'b1; al1 = 8'd32;
                                end else begin
                                    al1 = b;
                                end
                                n.l1 = al1;
                            end else if (o == 7'd10) begin
                                if (b > 8'd15) begin
                                    n.rej = 1'b1; al2 = 8'd15;
                                end else begin
                                    al2 = b;
                                end
                                n.l2 = al2;
                                if (cur.hf < EPOCH_FLOOR || cur.hs < cur.hf) n.rej = 1'b1;
                            end else begin
                                tx = text_run({3'd0, o} - 10'd11, {8'd0, cur.l1},
                                              {8'd0, cur.l2}, 16'd0,
                                              F_AG_TITLE, F_AG_LOC, F_AG_LOC);
                            end
                            if (o >= 7'd10 &&
                                {3'd0, o} == 10'd10 + {2'd0, al1} + {2'd0, al2}) begin
                                n.eidx = cur.eidx + 4'd1;
                                n.eoff = '0;
                            end else begin
                                n.eoff = o + 7'd1;
                            end
                        end
                    end
                    K_BATTERY:
                    begin
                        if (p == 10'd2) begin
                            fv = 1'b1; fid = F_BAT_PCT; fvl = {25'd0, b};
                            if (b > 8'd100) n.rej = 1'b1;
                        end else if (p == 10'd3) begin
                            n.flags = b; fv = 1'b1; fid = F_BAT_FLAGS; fvl = {25'd0, b};
                            if (b[7:2] != '0) n.rej = 1'b1;
                        end else if (p == 10'd4) begin
                            if (b != '0) n.rej = 1'b1;
                        end
                    end
                    K_CALL:
                    begin
                        if (p == 10'd2) begin
                            n.flags = b; fv = 1'b1; fid = F_CALL_FLAGS; fvl = {25'd0, b};
                            if (b[7:5] != '0) n.rej = 1'b1;
                        end else if (p == 10'd3) begin
                            n.l1 = b; if (b > 8'd48) n.rej = 1'b1;
                        end else if (p <= 10'd7) begin
                            w = gather(cur.asmw, lo2(p - 10'd4), b);
                            n.asmw = w;
                            if (p == 10'd7) begin
                                n.hf = w; fv = 1'b1; fid = F_CALL_SESSION; fvl = {1'b0, w};
                            end
                        end else if (p <= 10'd9) begin
                            w = gather(cur.asmw, lo2(p - 10'd8), b);
                            n.asmw = w;
                            if (p == 10'd9) begin
                                n.hs = w; fv = 1'b1; fid = F_CALL_GEN; fvl = {1'b0, w};
                            end
                        end else begin
                            tx = text_run(p - 10'd10, {8'd0, cur.l1}, 16'd0, 16'd0,
                                          F_CALL_LABEL, F_CALL_LABEL, F_CALL_LABEL);
                        end
                    end
                    K_REPLY:
                    begin
                        if (p == 10'd2) begin
                            if (b == '0) n.rej = 1'b1;
                        end else if (p == 10'd3) begin
                            fv = 1'b1; fid = F_RPL_STATUS; fvl = {25'd0, b};
                            if (b > 8'd5) n.rej = 1'b1;
                        end else if (p <= 10'd7) begin
                            w = gather(cur.asmw, lo2(p - 10'd4), b);
                            n.asmw = w;
                            if (p == 10'd7) begin
                                n.hf = w; fv = 1'b1; fid = F_RPL_NOTIF; fvl = {1'b0, w};
                            end
                        end else if (p <= 10'd11) begin
                            w = gather(cur.asmw, lo2(p - 10'd8), b);
                            n.asmw = w;
                            if (p == 10'd11) begin
                                n.hs = w; fv = 1'b1; fid = F_RPL_NONCE; fvl = {1'b0, w};
                            end
                        end
                    end
                    K_WIFI_PROV:
                    begin
                        if (p == 10'd2) begin
                            n.l1 = b; fv = 1'b1; fid = F_WP_SSID_LEN; fvl = {25'd0, b};
                            if (b == '0 || b > 8'd32) n.rej = 1'b1;
                        end else if (p == 10'd3) begin
                            n.l2 = b; fv = 1'b1; fid = F_WP_PASS_LEN; fvl = {25'd0, b};
                            if (b > 8'd64) n.rej = 1'b1;
                        end else begin
                            tx = text_run(p - 10'd4, {8'd0, cur.l1}, {8'd0, cur.l2}, 16'd0,
                                          F_WP_SSID, F_WP_PASS, F_WP_PASS);
                        end
                    end
                    K_WX_SET:
                    begin
                        if (p == 10'd2) begin
                            n.flags = b; fv = 1'b1; fid = F_WS_FLAGS; fvl = {25'd0, b};
                            if (b[7:2] != '0) n.rej = 1'b1;
                        end else if (p == 10'd3) begin
                            fv = 1'b1; fid = F_WS_METRIC; fvl = {25'd0, b};
                            if (b > 8'd1) n.rej = 1'b1;
                        end else if (p <= 10'd5) begin
                            w = gather(cur.asmw, lo2(p - 10'd4), b);
                            n.asmw = w;
                            if (p == 10'd5) begin
                                fv = 1'b1; fid = F_WS_REFRESH; fvl = {1'b0, w};
                                if (w < 32'd15 || w > 32'd360) n.rej = 1'b1;
                            end
                        end else if (p <= 10'd9) begin
                            w = gather(cur.asmw, lo2(p - 10'd6), b);
                            n.asmw = w;
                            s32 = $signed(w);
                            if (p == 10'd9) begin
                                fv = 1'b1; fid = F_WS_LAT; fvl = {s32[31], s32};
                                if (s32 < -32'sd90000000 || s32 > 32'sd90000000) n.rej = 1'b1;
                            end
                        end else if (p <= 10'd13) begin
                            w = gather(cur.asmw, lo2(p - 10'd10), b);
                            n.asmw = w;
                            s32 = $signed(w);
                            if (p == 10'd13) begin
                                fv = 1'b1; fid = F_WS_LON; fvl = {s32[31], s32};
                                if (s32 < -32'sd180000000 || s32 > 32'sd180000000)
                                    n.rej = 1'b1;
                            end
                        end
                    end
                    K_WX_SNAP:
                    begin
                        if (p == 10'd2) begin
                            n.flags = b; fv = 1'b1; fid = F_SN_FLAGS; fvl = {25'd0, b};
                            if (b[7:2] != '0) n.rej = 1'b1;
                        end else if (p == 10'd3) begin
                            if (b != '0) n.rej = 1'b1;
                        end else if (p <= 10'd7) begin
                            w = gather(cur.asmw, lo2(p - 10'd4), b);
                            n.asmw = w;
                            if (p == 10'd7) begin
                                n.hf = w; fv = 1'b1; fid = F_SN_OBSERVED; fvl = {1'b0, w};
                                if (w < EPOCH_FLOOR) n.rej = 1'b1;
                            end
                        end else if (p <= 10'd9) begin
                            w = gather(cur.asmw, lo2(p - 10'd8), b);
                            n.asmw = w;
                            if (p == 10'd9) begin
                                n.hs = w; fv = 1'b1; fid = F_SN_AGE; fvl = {1'b0, w};
                                if (w > 32'd21600 || cur.hf < w) n.rej = 1'b1;
                            end
                        end else if (p <= 10'd13) begin
                            // temperatures: two 16-bit halves, low byte on even position
                            w = gather(cur.asmw, {1'b0, p[0]}, b);
                            n.asmw = w;
                            s16 = $signed(w[15:0]);
                            if (p == 10'd11 || p == 10'd13) begin
                                fv = 1'b1;
                                fid = (p == 10'd11) ? F_SN_TEMP : F_SN_APPARENT;
                                fvl = {{17{s16[15]}}, s16};
                                if (s16 < -16'sd1500 || s16 > 16'sd1500) n.rej = 1'b1;
                            end
                        end else if (p <= 10'd17) begin
                            w = gather(cur.asmw, {1'b0, p[0]}, b);
                            n.asmw = w;
                            if (p == 10'd15) begin
                                fv = 1'b1; fid = F_SN_CODE; fvl = {1'b0, w};
                                if (w > 32'd999) n.rej = 1'b1;
                            end
                            if (p == 10'd17) begin
                                fv = 1'b1; fid = F_SN_WIND; fvl = {1'b0, w};
                                if (w > 32'd5000) n.rej = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (tx.v) begin
                    fv  = 1'b1;
                    fid = tx.fid;
                    fix = tx.idx;
                    fvl = {25'd0, clean(b)};
                end
            end
        end

        // verdict from the updated parse state
        nb   = {8'd0, p} + 18'd1;
        kv   = kind_of(n.mtype);
        idle = (n.flags[1:0] == 2'b00);
        case (kv)
            K_UPSERT:
                ok = nb == 18'd11 + {10'd0, n.l1} + {10'd0, n.l2} + {2'd0, n.l3};
            K_REMOVE: ok = nb == 18'd6 && n.hf != '0;
            K_CLEAR, K_WIFI_CLEAR, K_PEER_FORGET: ok = nb == 18'd2;
            K_MEDIA:
                ok = nb == 18'd5 + {10'd0, n.l1} + {10'd0, n.l2} &&
                     (n.flags[1] || (!n.flags[0] && n.l1 == '0 && n.l2 == '0));
            K_PROGRESS:
                ok = nb == 18'd13 + {10'd0, n.l1} + {10'd0, n.l2} &&
                     n.hs <= PROGRESS_MAX && (n.hs == '0 || n.hf <= n.hs) &&
                     (n.flags[1] || (!n.flags[0] && !n.flags[2] && n.hf == '0 &&
                      n.hs == '0 && n.l1 == '0 && n.l2 == '0));
            K_AGENDA: ok = nb >= 18'd3 && n.eidx == n.ecnt;
            K_BATTERY: ok = nb == 18'd5;
            K_CALL:
                ok = nb == 18'd10 + {10'd0, n.l1} && n.flags[1:0] != 2'b11 &&
                     !(n.flags[3] && !n.flags[0]) && !(n.flags[4] && idle) &&
                     (idle ? (n.hf == '0 && n.hs == '0) : (n.hf != '0 && n.hs != '0));
            K_REPLY: ok = nb == 18'd12 && n.hf != '0 && n.hs != '0;
            K_WIFI_PROV: ok = nb == 18'd4 + {10'd0, n.l1} + {10'd0, n.l2};
            K_WX_SET: ok = nb == 18'd14 && (!n.flags[0] || n.flags[1]);
            K_WX_SNAP: ok = nb == 18'd18;
            default: ok = 1'b0;
        endcase

        ver_vld = frame_end;
        ver = '{kind: kv, field_id: F_VERDICT, item_index: 7'd0, value: 33'sd0,
                is_verdict: 1'b1, accepted: (p < POS_LIMIT) && ok && !n.rej, last: 1'b1};
        fld_vld = fv;
        fld = '{kind: kd, field_id: fid, item_index: fix, value: fvl,
                is_verdict: 1'b0, accepted: 1'b0, last: !frame_end};
        nxt = frame_end ? '0 : n;
    end

endmodule
`default_nettype wire

### rtl/cfp_result_queue.sv
`default_nettype none
module cfp_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_a,
    input  cfp_pkg::result_t data_a,
    input  logic             push_b,
    input  cfp_pkg::result_t data_b,
    output logic             room,
    output logic             head_vld,
    output cfp_pkg::result_t head,
    input  logic             pop
);
    import cfp_pkg::*;

    result_t    q_reg [4];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;
    logic [1:0] wp_b;
    logic [1:0] wp_next;
    logic [2:0] cnt_next;

    assign wp_b     = push_a ? wp_reg + 2'd1 : wp_reg;
    assign wp_next  = push_b ? wp_b + 2'd1 : wp_b;
    assign cnt_next = cnt_reg + {2'd0, push_a} + {2'd0, push_b} - {2'd0, pop};
    assign room     = cnt_reg <= 3'd2;
    assign head_vld = cnt_reg != 3'd0;
    assign head     = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push_a) q_reg[wp_reg] <= data_a;
        if (push_b) q_reg[wp_b] <= data_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            cnt_reg <= cnt_next;
            if (pop) rp_reg <= rp_reg + 2'd1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4) else $error("result queue overfull");
    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_a || push_b) |-> cnt_reg <= 3'd3) else $error("push without room");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (!push_a && !push_b && !pop) |=> cnt_reg == $past(cnt_reg))
        else $error("count moved while idle");

endmodule
`default_nettype wire
